// File: rtl/core/rxmap_pkg.sv
// ----------------------------------------------------------------------------
// rxmap_pkg
// shared types and constants of the receive channel mapping block
// ----------------------------------------------------------------------------
package rxmap_pkg;

  localparam int ADDR_CHANNELS = 128;
  localparam int RX_CHANNELS   = 32;
  localparam int MAX_MAPPINGS  = 128;

  localparam int CH_W   = $clog2(ADDR_CHANNELS);
  localparam int RX_W   = $clog2(RX_CHANNELS);
  localparam int ID_W   = $clog2(MAX_MAPPINGS);
  localparam int CNT_W  = $clog2(MAX_MAPPINGS + 1);
  localparam int NCNT_W = $clog2(RX_CHANNELS + 1);
  localparam int STORE_AW = ID_W + RX_W;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_OVER = 2'd1,
    ST_DUP  = 2'd2,
    ST_FULL = 2'd3
  } status_t;

  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_PROCESS = 1'b1;

  localparam logic [0:0] CFG_MASK_LOW  = 1'b0;
  localparam logic [0:0] CFG_MASK_HIGH = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_FILL,
    S_CMP_START,
    S_CMP,
    S_CMP_NEXT,
    S_WRITE,
    S_EMIT,
    S_ERR
  } state_t;

  typedef struct packed {
    logic       start;      // capture aperture, clear scan state
    logic       scan_step;  // look at one addressed channel
    logic       fill_step;  // append one unused receive channel
    logic       cmp_start;  // begin compare against entry cmp_id
    logic       cmp_step;   // compare one slot
    logic       cmp_next;   // move to next stored mapping
    logic       write_step; // store one slot of new mapping
    logic       emit_load;  // present result of current slot
    logic       err_load;   // present error result
    status_t    err_code;
    logic       out_take;   // output register consumed
  } cmd_t;

  typedef struct packed {
    logic scan_done;
    logic over;
    logic dup;
    logic fill_done;
    logic cmp_slot_done;
    logic cmp_mismatch;
    logic cmp_match;
    logic cmp_last_entry;
    logic no_entries;
    logic full;
    logic write_done;
    logic emit_last;
    logic out_valid;
    logic out_ready;
  } stat_t;

endpackage

// File: rtl/core/rxmap_ctrl.sv
// ----------------------------------------------------------------------------
// rxmap_ctrl
// sequencer of scan, fill, compare, store and emit phases
// ----------------------------------------------------------------------------
module rxmap_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_go,
  input  rxmap_pkg::stat_t stat,
  output rxmap_pkg::cmd_t  cmd,
  output logic            busy
);
  import rxmap_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (in_go) state_next = S_SCAN;
      S_SCAN: begin
        if (stat.over) state_next = S_ERR;
        else if (stat.scan_done) state_next = stat.dup ? S_ERR : S_FILL;
      end
      S_FILL: if (stat.fill_done) state_next = stat.no_entries ?
                (stat.full ? S_ERR : S_WRITE) : S_CMP_START;
      S_CMP_START: state_next = S_CMP;
      S_CMP: begin
        if (stat.cmp_mismatch || stat.cmp_slot_done) begin
          if (stat.cmp_match) state_next = S_EMIT;
          else if (stat.cmp_last_entry) state_next = stat.full ? S_ERR : S_WRITE;
          else state_next = S_CMP_NEXT;
        end
      end
      S_CMP_NEXT: state_next = S_CMP_START;
      S_WRITE: if (stat.write_done) state_next = S_EMIT;
      S_EMIT: if (!stat.out_valid || stat.out_ready)
                if (stat.emit_last) state_next = S_IDLE;
      S_ERR: if (!stat.out_valid || stat.out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.err_code = ST_OK;
    cmd.out_take = stat.out_valid && stat.out_ready;
    busy = (state != S_IDLE);
    case (state)
      S_IDLE: cmd.start = in_go;
      S_SCAN: cmd.scan_step = 1'b1;
      S_FILL: cmd.fill_step = 1'b1;
      S_CMP_START: cmd.cmp_start = 1'b1;
      S_CMP: cmd.cmp_step = 1'b1;
      S_CMP_NEXT: cmd.cmp_next = 1'b1;
      S_WRITE: cmd.write_step = !stat.write_done;
      S_EMIT: cmd.emit_load = !stat.out_valid || stat.out_ready;
      S_ERR: begin
        cmd.err_load = !stat.out_valid || stat.out_ready;
        cmd.err_code = stat.over ? ST_OVER : (stat.dup ? ST_DUP : ST_FULL);
      end
      default: ;
    endcase
  end

endmodule

// File: rtl/core/rxmap_dp.sv
// ----------------------------------------------------------------------------
// rxmap_dp
// channel table, scan registers, mapping store and output register
// ----------------------------------------------------------------------------
module rxmap_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  rxmap_pkg::cmd_t               cmd,
  output rxmap_pkg::stat_t              stat,
  input  logic                          tbl_we,
  input  logic [rxmap_pkg::CH_W-1:0]    tbl_addr,
  input  logic [7:0]                    tbl_value,
  input  logic [63:0]                   ap_low,
  input  logic [63:0]                   ap_high,
  input  logic [63:0]                   mask_low,
  input  logic [63:0]                   mask_high,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    status,
  output logic [6:0]                    map_id,
  output logic                          is_new,
  output logic [4:0]                    slot,
  output logic [4:0]                    rx_channel,
  output logic [63:0]                   kept_low,
  output logic [63:0]                   kept_high,
  output logic                          last
);
  import rxmap_pkg::*;

  logic [RX_W-1:0] chan_tab [ADDR_CHANNELS];
  logic [RX_W-1:0] store [MAX_MAPPINGS*RX_CHANNELS];
  logic [RX_W-1:0] map_buf [RX_CHANNELS];

  logic [ADDR_CHANNELS-1:0] ap, kept, mask;
  logic [RX_CHANNELS-1:0]   used;
  logic [CH_W:0]            ch;
  logic [NCNT_W-1:0]        n;
  logic [RX_W:0]            fi;
  logic                     dup, over;
  logic [CNT_W-1:0]         count;
  logic [ID_W-1:0]          cmp_id;
  logic [RX_W:0]            ci;
  logic [RX_W-1:0]          store_q;
  logic                     match, mismatch;
  logic [RX_W:0]            ei;
  logic [ID_W-1:0]          res_id;
  logic                     res_new;
  logic [RX_W-1:0]          tab_q;
  logic                     pend, ap_bit;

  assign mask   = {mask_high, mask_low};
  assign ap_bit = ap[ch[CH_W-1:0]];

  // channel table, registered read of the entry at ch into tab_q
  always_ff @(posedge clk) begin
    if (tbl_we) chan_tab[tbl_addr] <= tbl_value[RX_W-1:0];
    tab_q <= chan_tab[ch[CH_W-1:0]];
  end

  // scan: ch issues read, pend marks that tab_q holds channel ch-1 and it is active
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      ap <= {ap_high, ap_low};
      kept <= '0;
      used <= '0;
      ch <= '0;
      n <= '0;
      fi <= '0;
      dup <= 1'b0;
      over <= 1'b0;
      pend <= 1'b0;
    end else if (cmd.scan_step) begin
      if (pend) begin
        if (n == NCNT_W'(RX_CHANNELS)) over <= 1'b1;
        else begin
          if (used[tab_q]) dup <= 1'b1;
          else if (!mask[ch[CH_W-1:0] - 1'b1]) kept[ch[CH_W-1:0] - 1'b1] <= 1'b1;
          used[tab_q] <= 1'b1;
          map_buf[n[RX_W-1:0]] <= tab_q;
          n <= n + 1'b1;
        end
      end
      if (ch != (CH_W+1)'(ADDR_CHANNELS)) begin
        pend <= ap_bit;
        ch <= ch + 1'b1;
      end else pend <= 1'b0;
    end else if (cmd.fill_step) begin
      if (n != NCNT_W'(RX_CHANNELS) && !used[fi[RX_W-1:0]]) begin
        map_buf[n[RX_W-1:0]] <= fi[RX_W-1:0];
        n <= n + 1'b1;
      end
      fi <= fi + 1'b1;
    end
  end

  assign stat.scan_done = (ch == (CH_W+1)'(ADDR_CHANNELS)) && !pend;
  assign stat.over      = over;
  assign stat.dup       = dup;
  assign stat.fill_done = (n == NCNT_W'(RX_CHANNELS)) || fi == (RX_W+1)'(RX_CHANNELS);

  // mapping store, one slot per cycle
  always_ff @(posedge clk) begin
    if (cmd.write_step) store[{count[ID_W-1:0], ci[RX_W-1:0]}] <= map_buf[ci[RX_W-1:0]];
    store_q <= store[{cmp_id, ci[RX_W-1:0]}];
  end

  always_ff @(posedge clk) begin
    if (rst) count <= '0;
    else if (cmd.write_step && ci == (RX_W+1)'(RX_CHANNELS-1)) count <= count + 1'b1;
  end

  // compare: ci issues read, compare uses previous ci
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      cmp_id <= '0;
      ci <= '0;
      match <= 1'b0;
      mismatch <= 1'b0;
    end else if (cmd.fill_step && stat.fill_done) begin
      ci <= '0;
    end else if (cmd.cmp_start) begin
      ci <= (RX_W+1)'(1);
      mismatch <= 1'b0;
    end else if (cmd.cmp_step && !mismatch && !match) begin
      if (store_q != map_buf[ci[RX_W-1:0] - 1'b1]) mismatch <= 1'b1;
      else if (ci == (RX_W+1)'(RX_CHANNELS)) match <= 1'b1;
      else ci <= ci + 1'b1;
    end else if (cmd.cmp_next) begin
      cmp_id <= cmp_id + 1'b1;
      ci <= '0;
    end else if (cmd.write_step) begin
      ci <= ci + 1'b1;
    end
    if (cmd.cmp_step && (mismatch || match) && !match) ci <= '0;
  end

  assign stat.cmp_mismatch   = mismatch;
  assign stat.cmp_slot_done  = match;
  assign stat.cmp_match      = match;
  assign stat.cmp_last_entry = (CNT_W'(cmp_id) + 1'b1 == count);
  assign stat.no_entries     = (count == '0);
  assign stat.full           = (count == CNT_W'(MAX_MAPPINGS));
  assign stat.write_done     = (ci == (RX_W+1)'(RX_CHANNELS));

  // result id and emit counter
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      ei <= '0;
      res_new <= 1'b0;
    end else if (cmd.cmp_step && match) begin
      res_id <= cmp_id;
    end else if (cmd.write_step && ci == '0) begin
      res_id <= count[ID_W-1:0];
      res_new <= 1'b1;
    end else if (cmd.emit_load) begin
      ei <= ei + 1'b1;
    end
  end

  assign stat.emit_last = (ei == (RX_W+1)'(RX_CHANNELS-1));

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (cmd.emit_load || cmd.err_load) out_valid <= 1'b1;
    else if (cmd.out_take) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_load) begin
      status <= ST_OK;
      map_id <= 7'(res_id);
      is_new <= res_new;
      slot <= 5'(ei[RX_W-1:0]);
      rx_channel <= 5'(map_buf[ei[RX_W-1:0]]);
      kept_low <= kept[63:0];
      kept_high <= kept[127:64];
      last <= stat.emit_last;
    end else if (cmd.err_load) begin
      status <= cmd.err_code;
      map_id <= '0;
      is_new <= 1'b0;
      slot <= '0;
      rx_channel <= '0;
      kept_low <= '0;
      kept_high <= '0;
      last <= 1'b1;
    end
  end

  assign stat.out_valid = out_valid;
  assign stat.out_ready = out_ready;

endmodule

// File: rtl/core/rx_channel_mapping_dedup.sv
// ----------------------------------------------------------------------------
// rx_channel_mapping_dedup
// receive channel mapping with duplicate mapping detection
// ----------------------------------------------------------------------------
// input channel (in_valid/in_ready): op 0 loads one channel table entry; op 1
// processes a 128-channel aperture.
// output channel (out_valid/out_ready): a processed aperture yields 32
// transactions, one per slot, with last on the final one; an error yields one
// transaction with last set.
// sequence: a scan of the addressed channels (one addressed channel per cycle
// through the registered channel table), a fill with unused receive channels,
// a compare against each stored mapping (one slot per cycle on the store read
// port), a store of a new mapping if none matched, and emission of the slots.
// one aperture is worked on at a time; in_ready is low while busy.
// reset clears the stored-mapping count and the masks; the channel table
// holds nothing until loaded.
// a stall on out_ready holds the output register and pauses emission.
// ----------------------------------------------------------------------------
module rx_channel_mapping_dedup (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        op,
  input  logic [6:0]  table_index,
  input  logic [7:0]  table_value,
  input  logic [63:0] aperture_low,
  input  logic [63:0] aperture_high,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [6:0]  map_id,
  output logic        is_new,
  output logic [4:0]  slot,
  output logic [4:0]  rx_channel,
  output logic [63:0] kept_low,
  output logic [63:0] kept_high,
  output logic        last
);
  import rxmap_pkg::*;

  logic [63:0] mask_low, mask_high;
  cmd_t  cmd;
  stat_t stat;
  logic  busy, acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      mask_low <= '0;
      mask_high <= '0;
    end else if (cfg_we) begin
      if (cfg_index == CFG_MASK_LOW) mask_low <= cfg_data;
      if (cfg_index == CFG_MASK_HIGH) mask_high <= cfg_data;
    end
  end

  assign in_ready = !busy;
  assign acc = in_valid && in_ready;

  rxmap_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .in_go(acc && op == OP_PROCESS),
    .stat (stat),
    .cmd  (cmd),
    .busy (busy)
  );

  rxmap_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .tbl_we    (acc && op == OP_LOAD),
    .tbl_addr  (table_index),
    .tbl_value (table_value),
    .ap_low    (aperture_low),
    .ap_high   (aperture_high),
    .mask_low  (mask_low),
    .mask_high (mask_high),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .map_id    (map_id),
    .is_new    (is_new),
    .slot      (slot),
    .rx_channel(rx_channel),
    .kept_low  (kept_low),
    .kept_high (kept_high),
    .last      (last)
  );

endmodule

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for rx_channel_mapping_dedup
// ----------------------------------------------------------------------------
// loads the channel table entries that apertures use, then drives apertures
// and table updates on the input channel. Every accepted transaction runs
// through a bench-side model of the scan, fill and mapping store. The expected
// per-slot results are queued and compared field by field with each output
// transaction.
// Covered: empty and full apertures, over-count, duplicate receive channels,
// masking and mapping reuse. Both sides stall at random, and one long output
// hold-off backs up the input.
// ----------------------------------------------------------------------------
module tb;
  import rxmap_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 40000;

  typedef struct {
    status_t     status;
    logic [6:0]  map_id;
    logic        is_new;
    logic [4:0]  slot;
    logic [4:0]  rx_channel;
    logic [63:0] kept_low;
    logic [63:0] kept_high;
    logic        last;
  } slot_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [0:0]  cfg_index = CFG_MASK_LOW;
  logic [63:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        op = OP_LOAD;
  logic [6:0]  table_index = '0;
  logic [7:0]  table_value = '0;
  logic [63:0] aperture_low = '0;
  logic [63:0] aperture_high = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  status;
  logic [6:0]  map_id;
  logic        is_new;
  logic [4:0]  slot;
  logic [4:0]  rx_channel;
  logic [63:0] kept_low;
  logic [63:0] kept_high;
  logic        last;

  rx_channel_mapping_dedup uut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .op(op), .table_index(table_index), .table_value(table_value),
    .aperture_low(aperture_low), .aperture_high(aperture_high),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .map_id(map_id), .is_new(is_new), .slot(slot),
    .rx_channel(rx_channel), .kept_low(kept_low), .kept_high(kept_high),
    .last(last)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // bench copy of the block state
  logic [4:0]   chan_map [ADDR_CHANNELS];
  logic [127:0] loaded;
  logic [159:0] stored_maps [MAX_MAPPINGS];
  int           stored_count;
  logic [127:0] off_mask;

  slot_result_t pending_slots[$];
  logic [127:0] aperture_history[$];

  int errors;
  int send_idle_pct;
  int recv_stall_pct;
  int hold_cycles;
  int idle_cycles;
  int n_loads, n_new, n_match, n_over, n_dup, n_full;
  slot_result_t got;

  task automatic report_mismatch(input string what, input logic [63:0] act,
                                 input logic [63:0] exp_val);
    errors++;
    $display("mismatch %s: got %0h expected %0h at %0t", what, act, exp_val, $realtime);
  endtask

  task automatic queue_result(input slot_result_t r);
    pending_slots = {pending_slots, r};
  endtask

  task automatic push_error(input status_t code);
    slot_result_t r;
    r = '{status: code, map_id: '0, is_new: 1'b0, slot: '0, rx_channel: '0,
          kept_low: '0, kept_high: '0, last: 1'b1};
    queue_result(r);
    case (code)
      ST_OVER: n_over++;
      ST_DUP:  n_dup++;
      default: n_full++;
    endcase
  endtask

  task automatic predict_operation(input logic o, input logic [6:0] idx,
                                   input logic [7:0] val, input logic [127:0] ap);
    logic [159:0] mapping;
    logic [31:0]  used;
    logic [127:0] kept;
    logic [4:0]   rx;
    logic         dup;
    logic         found;
    int           n;
    int           id;
    slot_result_t r;
    mapping = '0;
    used = '0;
    kept = '0;
    dup = 1'b0;
    found = 1'b0;
    n = 0;
    id = 0;
    if (o == OP_LOAD) begin
      chan_map[idx] = val % RX_CHANNELS;
      loaded[idx] = 1'b1;
      n_loads++;
      return;
    end
    for (int c = 0; c < ADDR_CHANNELS; c++) begin
      if (ap[c]) begin
        if (n >= RX_CHANNELS) begin
          push_error(ST_OVER);
          return;
        end
        rx = chan_map[c];
        if (used[rx]) dup = 1'b1;
        else if (!off_mask[c]) kept[c] = 1'b1;
        used[rx] = 1'b1;
        mapping[n*5 +: 5] = rx;
        n++;
      end
    end
    if (dup) begin
      push_error(ST_DUP);
      return;
    end
    for (int i = 0; i < RX_CHANNELS; i++) begin
      if (!used[i] && n < RX_CHANNELS) begin
        mapping[n*5 +: 5] = i[4:0];
        n++;
      end
    end
    for (int i = 0; i < stored_count; i++) begin
      if (!found && stored_maps[i] == mapping) begin
        found = 1'b1;
        id = i;
      end
    end
    if (!found) begin
      if (stored_count >= MAX_MAPPINGS) begin
        push_error(ST_FULL);
        return;
      end
      id = stored_count;
      stored_maps[id] = mapping;
      stored_count++;
      n_new++;
    end else begin
      n_match++;
    end
    for (int i = 0; i < RX_CHANNELS; i++) begin
      r = '{status: ST_OK, map_id: id[6:0], is_new: !found, slot: i[4:0],
            rx_channel: mapping[i*5 +: 5], kept_low: kept[63:0],
            kept_high: kept[127:64], last: (i == RX_CHANNELS - 1)};
      queue_result(r);
    end
  endtask

  // offer one transaction, return at the edge where it is accepted
  task automatic send_item(input logic o, input logic [6:0] idx,
                           input logic [7:0] val, input logic [127:0] ap);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    op <= o;
    table_index <= idx;
    table_value <= val;
    aperture_low <= ap[63:0];
    aperture_high <= ap[127:64];
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_operation(o, idx, val, ap);
  endtask

  task automatic send_aperture(input logic [127:0] ap);
    send_item(OP_PROCESS, 7'($urandom), 8'($urandom), ap);
  endtask

  task automatic send_load(input logic [6:0] idx, input logic [7:0] val);
    send_item(OP_LOAD, idx, val, {$urandom, $urandom, $urandom, $urandom});
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_slots.size() > 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic set_masks(input logic [63:0] lo, input logic [63:0] hi);
    cfg_we <= 1'b1;
    cfg_index <= CFG_MASK_LOW;
    cfg_data <= lo;
    @(posedge clk);
    cfg_index <= CFG_MASK_HIGH;
    cfg_data <= hi;
    @(posedge clk);
    cfg_we <= 1'b0;
    off_mask = {hi, lo};
  endtask

  // only loaded channels are picked
  function automatic logic [127:0] pick_aperture(input int k);
    logic [127:0] ap;
    logic [31:0]  taken;
    int           tries;
    int           c;
    ap = '0;
    taken = '0;
    tries = 0;
    while ($countones(ap) < k && tries < 2000) begin
      c = $urandom_range(ADDR_CHANNELS - 1);
      if (loaded[c] && !ap[c] && !taken[chan_map[c]]) begin
        ap[c] = 1'b1;
        taken[chan_map[c]] = 1'b1;
      end
      tries++;
    end
    return ap;
  endfunction

  function automatic logic [127:0] add_duplicate(input logic [127:0] ap);
    logic [31:0] taken;
    int          c;
    taken = '0;
    for (int i = 0; i < ADDR_CHANNELS; i++) if (ap[i]) taken[chan_map[i]] = 1'b1;
    for (int t = 0; t < 2000; t++) begin
      c = $urandom_range(ADDR_CHANNELS - 1);
      if (loaded[c] && !ap[c] && taken[chan_map[c]]) begin
        ap[c] = 1'b1;
        return ap;
      end
    end
    return ap;
  endfunction

  function automatic logic [127:0] random_well_formed;
    if ($urandom_range(9) == 0) return pick_aperture($urandom_range(20, 32));
    return pick_aperture($urandom_range(0, 8));
  endfunction

  // every entry an aperture touches is written before it is read
  task automatic test_table_load;
    for (int c = 0; c < 36; c++)
      send_load(c[6:0], 8'((c % RX_CHANNELS) + 32 * $urandom_range(7)));
    for (int c = ADDR_CHANNELS - 4; c < ADDR_CHANNELS; c++)
      send_load(c[6:0], 8'((c % RX_CHANNELS) + 32 * $urandom_range(7)));
    drain();
  endtask

  task automatic test_directed;
    logic [127:0] first32;
    first32 = {96'd0, 32'hffff_ffff};
    send_aperture('0);
    send_aperture('0);
    send_aperture(first32);
    send_aperture({1'b1, 127'd0});
    send_aperture(128'd1);
    send_aperture({4'hf, 124'd0});
    send_aperture('1);
    send_aperture({95'd0, 33'h1_ffff_ffff});
    send_aperture(128'd1 | (128'd1 << 32));
    send_aperture((128'd1 << 5) | (128'd1 << 125));
    send_load(7'd127, 8'd255);
    send_load(7'd0, 8'd0);
    send_aperture({1'b1, 126'd0, 1'b1});
    drain();
    set_masks('1, 64'h0);
    send_aperture(first32);
    send_aperture({4'hf, 124'd0});
    drain();
    set_masks(64'h0, '1);
    send_aperture({4'hf, 124'd0} | 128'd2);
    send_aperture(128'd4 | (128'd4 << 32));
    drain();
    set_masks({$urandom, $urandom}, {$urandom, $urandom});
    send_aperture(pick_aperture(12));
    send_aperture(pick_aperture(32));
    drain();
  endtask

  task automatic random_phase(input int count, input int idle_pct, input int stall_pct);
    logic [127:0] ap;
    int           pick;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      if (pick < 12) begin
        send_load(7'($urandom), 8'($urandom));
      end else if (pick < 20) begin
        if ($urandom_range(1)) ap = {$urandom, $urandom, $urandom, $urandom} & loaded;
        else ap = pick_aperture(32) | pick_aperture(8);
        send_aperture(ap);
      end else if (pick < 30) begin
        send_aperture(add_duplicate(pick_aperture($urandom_range(1, 20))));
      end else if (pick < 55 && aperture_history.size() > 0) begin
        send_aperture(aperture_history[$urandom_range(aperture_history.size() - 1)]);
      end else begin
        ap = random_well_formed();
        aperture_history = {aperture_history, ap};
        send_aperture(ap);
      end
    end
    drain();
  endtask

  task automatic test_random;
    random_phase(12, 0, 0);
    set_masks({$urandom, $urandom}, {$urandom, $urandom});
    random_phase(12, 64, 0);
    set_masks('0, '0);
    random_phase(12, 0, 64);
    set_masks({$urandom, $urandom}, '1);
    random_phase(12, 32, 32);
  endtask

  // output held off while the sender keeps offering
  task automatic test_backpressure;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    send_aperture(pick_aperture(3));
    hold_cycles = 3000;
    send_aperture(pick_aperture(4));
    send_aperture(pick_aperture(5));
    send_aperture('1);
    drain();
    send_aperture('0);
    drain();
  endtask

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_cycles > 0) begin
      out_ready <= 1'b0;
      hold_cycles--;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_slots.size() == 0) begin
        report_mismatch("unexpected transaction", {62'd0, status}, '0);
      end else begin
        got = pending_slots.pop_front();
        if (status != got.status) report_mismatch("status", status, got.status);
        if (map_id != got.map_id) report_mismatch("map_id", map_id, got.map_id);
        if (is_new != got.is_new) report_mismatch("is_new", is_new, got.is_new);
        if (slot != got.slot) report_mismatch("slot", slot, got.slot);
        if (rx_channel != got.rx_channel)
          report_mismatch("rx_channel", rx_channel, got.rx_channel);
        if (kept_low != got.kept_low) report_mismatch("kept_low", kept_low, got.kept_low);
        if (kept_high != got.kept_high)
          report_mismatch("kept_high", kept_high, got.kept_high);
        if (last != got.last) report_mismatch("last", last, got.last);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout with %0d results outstanding", pending_slots.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    errors = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_cycles = 0;
    idle_cycles = 0;
    stored_count = 0;
    off_mask = '0;
    loaded = '0;
    {n_loads, n_new, n_match, n_over, n_dup, n_full} = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    set_masks('0, '0);
    test_table_load();
    test_directed();
    test_random();
    test_backpressure();
    repeat (300) @(posedge clk);
    $display("covered %0d table loads, %0d new and %0d reused mappings", n_loads, n_new,
             n_match);
    $display("errors seen: %0d over-count, %0d duplicate, %0d store full", n_over, n_dup,
             n_full);
    if (errors == 0 && pending_slots.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/rxmap_pkg.sv
rtl/core/rxmap_ctrl.sv
rtl/core/rxmap_dp.sv
rtl/core/rx_channel_mapping_dedup.sv
tb/tb.sv
